[rtl/core/adjacency_matrix_graph_store_core_assert.svh]
// Assertion macros for the adjacency matrix graph store.
// Included by the top level; depends on nothing else.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_CORE_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define AMG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("graph store check failed");

// Next-cycle implication, off while reset is asserted.
`define AMG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("graph store check failed");

`endif

[rtl/core/amg_pkg.sv]
// Shared types for the adjacency matrix graph store: request codes and sequencer states.
// No dependencies.
package amg_pkg;

	typedef enum logic [2:0] {
		FN_SET   = 3'd0,
		FN_DEL   = 3'd1,
		FN_READ  = 3'd2,
		FN_FIRST = 3'd3,
		FN_NEXT  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE,
		ST_SCAN_FIRST,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

[rtl/core/adjacency_matrix_graph_store_core.sv]
// Weighted directed graph store held as an edge-weight matrix in one single-port memory.
// Depends on amg_pkg and adjacency_matrix_graph_store_core_assert.svh.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------------
//  config    | cfg_wr_en              | cfg_wr_data (vertices in use)
//  request   | in_valid / in_stall    | func, row_vertex, col_vertex, weight_in
//  result    | out_valid / out_stall  | weight_out, neighbor, edge_total, error
//
// Set, delete and read step through accept, memory read, read-modify-write and result.
// Rejected requests go from accept straight to result. A neighbor search reads one matrix word
// per cycle through the memory port, at most one word per vertex in use.
// After reset a clearing pass writes zero to all MAX_VERTICES * MAX_VERTICES words,
// one per cycle (1024 at the default), with in_stall high throughout.
// A finished result waits in the output register, and the next request is taken meanwhile.
`include "adjacency_matrix_graph_store_core_assert.svh"

module adjacency_matrix_graph_store_core
	import amg_pkg::*;
#(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              cfg_wr_en,
	input  logic [$clog2(MAX_VERTICES + 1) - 1:0]             cfg_wr_data,
	input  logic                                              in_valid,
	output logic                                              in_stall,
	input  logic [2:0]                                        func,
	input  logic [$clog2(MAX_VERTICES) - 1:0]                 row_vertex,
	input  logic [$clog2(MAX_VERTICES) - 1:0]                 col_vertex,
	input  logic [WEIGHT_BITS - 1:0]                          weight_in,
	output logic                                              out_valid,
	input  logic                                              out_stall,
	output logic [WEIGHT_BITS - 1:0]                          weight_out,
	output logic [$clog2(MAX_VERTICES + 1) - 1:0]             neighbor,
	output logic [$clog2(MAX_VERTICES * MAX_VERTICES + 1) - 1:0] edge_total,
	output logic                                              error
);

	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int DEPTH  = MAX_VERTICES * MAX_VERTICES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int EDGE_W = $clog2(DEPTH + 1);

	localparam logic [CNT_W-1:0]  N_MAX     = CNT_W'(MAX_VERTICES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [EDGE_W-1:0] EDGE_MAX  = EDGE_W'(DEPTH);

	state_t state_q, state_d;

	logic [CNT_W-1:0]       cfg_q;
	logic [CNT_W-1:0]       n_lim;
	logic [ADDR_W-1:0]      clr_q;
	logic [EDGE_W-1:0]      edge_cnt_q;

	func_t                  func_q;
	logic [VIDX_W-1:0]      row_q;
	logic [VIDX_W-1:0]      col_q;
	logic [WEIGHT_BITS-1:0] wt_q;

	logic [WEIGHT_BITS-1:0] res_wt_q;
	logic [CNT_W-1:0]       res_nb_q;
	logic                   res_err_q;

	logic                   out_valid_q;
	logic [WEIGHT_BITS-1:0] weight_out_q;
	logic [CNT_W-1:0]       neighbor_q;
	logic [EDGE_W-1:0]      edge_total_q;
	logic                   error_q;

	logic [WEIGHT_BITS-1:0] mem [DEPTH];
	logic [WEIGHT_BITS-1:0] rd_data_q;
	logic                   mem_we;
	logic                   mem_re;
	logic [ADDR_W-1:0]      mem_addr;
	logic [WEIGHT_BITS-1:0] mem_wdata;

	logic                   in_fire;
	logic                   out_free;
	logic                   row_ok;
	logic                   col_ok;
	logic [CNT_W-1:0]       start_col;
	logic                   acc_err;
	logic                   acc_lookup;
	logic                   acc_scan;
	logic [CNT_W-1:0]       acc_nb;
	logic [CNT_W-1:0]       cur_next;
	logic                   scan_hit;
	logic                   scan_last;
	logic [VIDX_W-1:0]      addr_col;

	assign n_lim    = (cfg_q > N_MAX) ? N_MAX : cfg_q;
	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Decode a request as it arrives
	always_comb begin
		row_ok     = CNT_W'(row_vertex) < n_lim;
		col_ok     = CNT_W'(col_vertex) < n_lim;
		start_col  = '0;
		acc_err    = 1'b0;
		acc_lookup = 1'b0;
		acc_scan   = 1'b0;
		acc_nb     = '0;
		unique case (func)
			FN_SET: begin
				if (!row_ok || !col_ok || weight_in == '0) acc_err = 1'b1;
				else acc_lookup = 1'b1;
			end
			FN_DEL, FN_READ: begin
				if (!row_ok || !col_ok) acc_err = 1'b1;
				else acc_lookup = 1'b1;
			end
			FN_FIRST: begin
				acc_nb = n_lim;
				if (!row_ok) acc_err = 1'b1;
				else acc_scan = 1'b1;
			end
			FN_NEXT: begin
				acc_nb    = n_lim;
				start_col = CNT_W'(col_vertex) + CNT_W'(1);
				if (!row_ok || !col_ok) acc_err = 1'b1;
				// next after the last vertex: answer none without reading
				else acc_scan = (start_col < n_lim);
			end
			default: acc_err = 1'b1;
		endcase
	end

	// Shared compare unit for the row scan
	assign cur_next  = CNT_W'(col_q) + CNT_W'(1);
	assign scan_hit  = (rd_data_q != '0);
	assign scan_last = (cur_next == n_lim);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire) begin
					priority if (acc_lookup) state_d = ST_LOOKUP;
					else if (acc_scan)       state_d = ST_SCAN_FIRST;
					else                     state_d = ST_DONE;
				end
			end
			ST_LOOKUP:     state_d = ST_UPDATE;
			ST_UPDATE:     state_d = ST_DONE;
			ST_SCAN_FIRST: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_hit || scan_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port controls
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = '0;
		addr_col  = col_q;
		unique case (state_q)
			ST_CLEAR:      mem_we = 1'b1;
			ST_LOOKUP:     mem_re = 1'b1;
			ST_UPDATE: begin
				mem_we    = (func_q == FN_SET) || (func_q == FN_DEL);
				mem_wdata = (func_q == FN_SET) ? wt_q : '0;
			end
			ST_SCAN_FIRST: mem_re = 1'b1;
			ST_SCAN: begin
				// fetch the following column while this one is checked
				addr_col = col_q + VIDX_W'(1);
				mem_re   = (cur_next < n_lim) && !scan_hit;
			end
			default: ;
		endcase
		if (state_q == ST_CLEAR) mem_addr = clr_q;
		else mem_addr = ADDR_W'(row_q) * ADDR_W'(MAX_VERTICES) + ADDR_W'(addr_col);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rd_data_q <= mem[mem_addr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cfg_q       <= N_MAX;
			clr_q       <= '0;
			edge_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) cfg_q <= cfg_wr_data;
			if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (state_q == ST_UPDATE) begin
				if (func_q == FN_SET && rd_data_q == '0)
					edge_cnt_q <= edge_cnt_q + EDGE_W'(1);
				else if (func_q == FN_DEL && rd_data_q != '0)
					edge_cnt_q <= edge_cnt_q - EDGE_W'(1);
			end
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q    <= func_t'(func);
			row_q     <= row_vertex;
			col_q     <= acc_scan ? VIDX_W'(start_col) : col_vertex;
			wt_q      <= weight_in;
			res_wt_q  <= '0;
			res_nb_q  <= acc_nb;
			res_err_q <= acc_err;
		end
		if (state_q == ST_UPDATE && func_q == FN_READ) res_wt_q <= rd_data_q;
		if (state_q == ST_SCAN) begin
			// hold the column on a hit or at the last column, advance otherwise
			if (scan_hit) res_nb_q <= CNT_W'(col_q);
			else if (scan_last) res_nb_q <= n_lim;
			else col_q <= col_q + VIDX_W'(1);
		end
		if (state_q == ST_DONE && out_free) begin
			weight_out_q <= res_wt_q;
			neighbor_q   <= res_nb_q;
			edge_total_q <= edge_cnt_q;
			error_q      <= res_err_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign weight_out = weight_out_q;
	assign neighbor   = neighbor_q;
	assign edge_total = edge_total_q;
	assign error      = error_q;

	`AMG_ASSERT_IMPL(a_edge_bound, clk, arst_n, 1'b1, edge_cnt_q <= EDGE_MAX)
	`AMG_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_fire, state_q != ST_IDLE)
	`AMG_ASSERT_IMPL(a_nb_range, clk, arst_n, out_valid_q, neighbor_q <= n_lim)
	`AMG_ASSERT_IMPL(a_clear_quiet, clk, arst_n, state_q == ST_CLEAR,
		edge_cnt_q == '0 && !out_valid_q)

endmodule

[sim/tb_adjacency_matrix_graph_store_core.sv]
// Self-checking testbench for the adjacency matrix graph store core.
// Depends on amg_pkg and the core; keeps a shadow matrix and checks every result in order.
module tb_adjacency_matrix_graph_store_core;
	import amg_pkg::*;

	localparam int VERTS           = 32;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int SETTLE_CYCLES   = 40;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PRINT_CAP       = 200;
	localparam int NUM_PHASES      = 10;

	// Codes beyond the defined request set
	localparam logic [2:0] FN_BAD_5 = 3'd5;
	localparam logic [2:0] FN_BAD_6 = 3'd6;
	localparam logic [2:0] FN_BAD_7 = 3'd7;

	typedef struct packed {
		logic [15:0] weight_out;
		logic [5:0]  neighbor;
		logic [10:0] edge_total;
		logic        error;
	} graph_answer_t;

	class graph_answer_board;
		logic [15:0]   shadow_weights [VERTS * VERTS];
		int unsigned   shadow_edges;
		int unsigned   shadow_vertices;
		graph_answer_t pending_answers [$];
		int unsigned   fails;

		function new();
			foreach (shadow_weights[i])
				shadow_weights[i] = '0;
			shadow_edges    = 0;
			shadow_vertices = VERTS;
			fails           = 0;
		endfunction

		function void set_vertices(logic [5:0] v);
			shadow_vertices = (v > VERTS) ? VERTS : v;
		endfunction

		function int unsigned pending();
			return pending_answers.size();
		endfunction

		task report_mismatch(string msg);
			// keep the log readable on a badly broken build
			if (fails < PRINT_CAP)
				$display("MISMATCH @%0t: %s", $realtime, msg);
			fails++;
		endtask

		function logic [5:0] scan_row(int unsigned r, int unsigned start);
			int unsigned c;
			for (c = start; c < shadow_vertices; c++)
				if (shadow_weights[r * VERTS + c] != 0)
					return c[5:0];
			return shadow_vertices[5:0];
		endfunction

		function void note_request(logic [2:0] f, logic [4:0] r, logic [4:0] c, logic [15:0] w);
			graph_answer_t ans;
			bit            row_ok;
			bit            col_ok;
			int unsigned   idx;
			ans    = '0;
			row_ok = r < shadow_vertices;
			col_ok = c < shadow_vertices;
			idx    = int'(r) * VERTS + int'(c);
			case (f)
				FN_SET: begin
					if (!row_ok || !col_ok || w == 0) begin
						ans.error = 1'b1;
					end else begin
						if (shadow_weights[idx] == 0)
							shadow_edges++;
						shadow_weights[idx] = w;
					end
				end
				FN_DEL: begin
					if (!row_ok || !col_ok) begin
						ans.error = 1'b1;
					end else if (shadow_weights[idx] != 0) begin
						shadow_edges--;
						shadow_weights[idx] = '0;
					end
				end
				FN_READ: begin
					if (!row_ok || !col_ok)
						ans.error = 1'b1;
					else
						ans.weight_out = shadow_weights[idx];
				end
				FN_FIRST: begin
					if (!row_ok) begin
						ans.error    = 1'b1;
						ans.neighbor = shadow_vertices[5:0];
					end else begin
						ans.neighbor = scan_row(r, 0);
					end
				end
				FN_NEXT: begin
					if (!row_ok || !col_ok) begin
						ans.error    = 1'b1;
						ans.neighbor = shadow_vertices[5:0];
					end else begin
						ans.neighbor = scan_row(r, int'(c) + 1);
					end
				end
				default: ans.error = 1'b1;
			endcase
			ans.edge_total = shadow_edges[10:0];
			pending_answers.push_back(ans);
		endfunction

		task check_answer(logic [15:0] wout, logic [5:0] nb, logic [10:0] et, logic err);
			graph_answer_t want;
			if (pending_answers.size() == 0) begin
				report_mismatch("result with no request outstanding");
				return;
			end
			want = pending_answers.pop_front();
			if (wout !== want.weight_out)
				report_mismatch($sformatf("weight_out %h, want %h", wout, want.weight_out));
			if (nb !== want.neighbor)
				report_mismatch($sformatf("neighbor %0d, want %0d", nb, want.neighbor));
			if (et !== want.edge_total)
				report_mismatch($sformatf("edge_total %0d, want %0d", et, want.edge_total));
			if (err !== want.error)
				report_mismatch($sformatf("error %b, want %b", err, want.error));
		endtask

		task flag_leftovers();
			if (pending_answers.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
		endtask
	endclass

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [5:0]  cfg_wr_data = 6'd0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [2:0]  func        = FN_READ;
	logic [4:0]  row_vertex  = '0;
	logic [4:0]  col_vertex  = '0;
	logic [15:0] weight_in   = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [15:0] weight_out;
	logic [5:0]  neighbor;
	logic [10:0] edge_total;
	logic        error;

	graph_answer_board board = new();

	bit          idle_on      = 1'b1;
	bit          hold_request = 1'b0;
	int unsigned hold_left    = 0;
	int unsigned cycle_count  = 0;

	adjacency_matrix_graph_store_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.row_vertex (row_vertex),
		.col_vertex (col_vertex),
		.weight_in  (weight_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.weight_out (weight_out),
		.neighbor   (neighbor),
		.edge_total (edge_total),
		.error      (error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// Result side: check on acceptance, then pick the next stall value
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				board.check_answer(weight_out, neighbor, edge_total, error);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= idle_on && ($urandom_range(0, 99) < 36);
			end
		end
	end

	task send_request(logic [2:0] f, logic [4:0] r, logic [4:0] c, logic [15:0] w);
		while (idle_on && $urandom_range(0, 99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		row_vertex <= r;
		col_vertex <= c;
		weight_in  <= w;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		board.note_request(f, r, c, w);
	endtask

	// Hold off until every result is in, then let the sequencer settle
	task drain_answers();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_vertices(logic [5:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_vertices(v);
	endtask

	// Mostly an index inside the live graph, now and then anything
	function logic [4:0] pick_vertex();
		if (board.shadow_vertices == 0 || $urandom_range(0, 9) == 0)
			return 5'($urandom);
		return 5'($urandom_range(0, board.shadow_vertices - 1));
	endfunction

	task send_random_request(bit sparse);
		int unsigned sel;
		int unsigned set_share;
		logic [2:0]  f;
		logic [15:0] w;
		set_share = sparse ? 15 : 30;
		sel       = $urandom_range(0, 99);
		if (sel < set_share)
			f = FN_SET;
		else if (sel < 45)
			f = FN_DEL;
		else if (sel < 65)
			f = FN_READ;
		else if (sel < 80)
			f = FN_FIRST;
		else if (sel < 95)
			f = FN_NEXT;
		else
			f = 3'($urandom_range(FN_BAD_5, FN_BAD_7));
		w = 16'($urandom);
		case ($urandom_range(0, 19))
			0: w = '0;
			1: w = 16'hFFFF;
			2: w = 16'h0001;
			default: ;
		endcase
		send_request(f, pick_vertex(), pick_vertex(), w);
	endtask

	initial begin
		logic [5:0]  phase_vertices [NUM_PHASES];
		int unsigned phase_items    [NUM_PHASES];
		bit          phase_sparse   [NUM_PHASES];
		int unsigned p;
		int unsigned k;

		phase_vertices = '{6'd32, 6'd1, 6'd2, 6'd32, 6'd63, 6'd0, 6'd17, 6'd0, 6'd40, 6'd31};
		phase_items    = '{300, 120, 150, 300, 250, 40, 200, 200, 150, 200};
		phase_sparse   = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
		phase_vertices[7] = 6'($urandom_range(3, 31));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the clearing pass
		repeat (2) @(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);

		write_vertices(6'd32);
		send_request(FN_READ, 5'd0, 5'd0, 16'h0000);
		send_request(FN_FIRST, 5'd0, 5'd17, 16'h0000);
		send_request(FN_SET, 5'd0, 5'd0, 16'h0001);
		send_request(FN_SET, 5'd0, 5'd31, 16'hFFFF);
		send_request(FN_SET, 5'd31, 5'd31, 16'h8000);
		send_request(FN_SET, 5'd5, 5'd5, 16'h0000);
		send_request(FN_READ, 5'd0, 5'd31, 16'h0000);
		send_request(FN_SET, 5'd0, 5'd31, 16'h1234);
		send_request(FN_FIRST, 5'd0, 5'd0, 16'h0000);
		send_request(FN_NEXT, 5'd0, 5'd0, 16'h0000);
		send_request(FN_NEXT, 5'd0, 5'd31, 16'h0000);
		send_request(FN_DEL, 5'd7, 5'd7, 16'h0000);
		send_request(FN_DEL, 5'd31, 5'd31, 16'h0000);
		send_request(FN_BAD_5, 5'd31, 5'd31, 16'hFFFF);
		send_request(FN_BAD_6, 5'd0, 5'd0, 16'h0001);
		send_request(FN_BAD_7, 5'd31, 5'd0, 16'hFFFF);
		drain_answers();

		// shrink: entries beyond the new size stay counted but out of reach
		write_vertices(6'd4);
		send_request(FN_SET, 5'd0, 5'd31, 16'h0005);
		send_request(FN_SET, 5'd3, 5'd3, 16'h00FF);
		send_request(FN_NEXT, 5'd0, 5'd3, 16'h0000);
		send_request(FN_FIRST, 5'd5, 5'd0, 16'h0000);
		send_request(FN_NEXT, 5'd0, 5'd4, 16'h0000);
		send_request(FN_READ, 5'd3, 5'd3, 16'h0000);
		drain_answers();

		write_vertices(6'd0);
		send_request(FN_FIRST, 5'd0, 5'd0, 16'h0000);
		send_request(FN_SET, 5'd0, 5'd0, 16'h0001);
		drain_answers();

		write_vertices(6'd63);
		send_request(FN_NEXT, 5'd0, 5'd0, 16'h0000);
		drain_answers();

		for (p = 0; p < NUM_PHASES; p++) begin
			write_vertices(phase_vertices[p]);
			// a stretch with no idling on either side
			idle_on = (p != 3);
			if (p == 0)
				hold_request = 1'b1;
			for (k = 0; k < phase_items[p]; k++) begin
				if (p == 4 && k == phase_items[p] / 2)
					drain_answers();
				send_random_request(phase_sparse[p]);
			end
			drain_answers();
		end

		board.flag_leftovers();
		if (board.fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
